// ----- src/gts_pkg.sv -----
package gts_pkg;

    localparam int SCORE_W = 16;
    localparam int TIME_W  = 32;
    localparam int CHAN_W  = 4;
    localparam int COUNT_W = 5;
    localparam int REG_IDX_W = 3;
    localparam int REG_DATA_W = 16;

    // Largest number of channels the channel field can reach.
    localparam int MAX_CHANNELS = 1 << CHAN_W;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_HOLD_MS   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOW_HOLD_MS    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COOLDOWN_MS    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_MODE     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT  = 3'd6;

    localparam logic [SCORE_W-1:0] HIGH_THRESHOLD_RST = 16'd45875;
    localparam logic [SCORE_W-1:0] LOW_THRESHOLD_RST  = 16'd19661;
    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST  = 5'd16;

    typedef struct packed {
        logic [SCORE_W-1:0] high_threshold;
        logic [SCORE_W-1:0] low_threshold;
        logic [15:0]        high_hold_ms;
        logic [15:0]        low_hold_ms;
        logic [15:0]        refire_gap_ms;
        logic               pulse_mode;
        logic [COUNT_W-1:0] channel_count;
    } cfg_t;

    typedef struct packed {
        logic               command;
        logic [CHAN_W-1:0]  channel;
        logic [SCORE_W-1:0] score;
        logic [TIME_W-1:0]  now_ms;
    } sample_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  out_channel;
        logic [SCORE_W-1:0] out_score;
        logic               fired;
        logic               active;
        logic [1:0]         phase;
    } result_t;

    typedef struct packed {
        logic              armed;
        logic              hold_running;
        logic [TIME_W-1:0] hold_start_ms;
        logic [TIME_W-1:0] last_fire_ms;
        logic              ever_fired;
        logic              output_latch;
    } chan_state_t;

endpackage

// ----- src/gts_if.sv -----
interface gts_sample_if;
    import gts_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [CHAN_W-1:0]    channel;
    logic [SCORE_W-1:0]   score;
    logic [TIME_W-1:0]    now_ms;

    modport source (output valid, command, channel, score, now_ms, input ready);
    modport sink   (input valid, command, channel, score, now_ms, output ready);
endinterface

interface gts_result_if;
    import gts_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHAN_W-1:0]    out_channel;
    logic [SCORE_W-1:0]   out_score;
    logic                 fired;
    logic                 active;
    logic [1:0]           phase;

    modport source (output valid, out_channel, out_score, fired, active, phase, input ready);
    modport sink   (input valid, out_channel, out_score, fired, active, phase, output ready);
endinterface

interface gts_cfg_if;
    import gts_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REG_IDX_W-1:0]    index;
    logic [REG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/gts_cfg_regs.sv -----
module gts_cfg_regs
    import gts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gts_cfg_if.sink   cfg,
    output cfg_t      cfg_q
);

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_threshold <= HIGH_THRESHOLD_RST;
            cfg_reg.low_threshold  <= LOW_THRESHOLD_RST;
            cfg_reg.high_hold_ms   <= '0;
            cfg_reg.low_hold_ms    <= '0;
            cfg_reg.refire_gap_ms  <= '0;
            cfg_reg.pulse_mode     <= 1'b0;
            cfg_reg.channel_count  <= CHANNEL_COUNT_RST;
        end
        else if (cfg.valid)
        begin
            // Writes to indices beyond the register list are dropped.
            unique case (cfg.index)
                REG_HIGH_THRESHOLD: cfg_reg.high_threshold <= cfg.data;
                REG_LOW_THRESHOLD:  cfg_reg.low_threshold  <= cfg.data;
                REG_HIGH_HOLD_MS:   cfg_reg.high_hold_ms   <= cfg.data;
                REG_LOW_HOLD_MS:    cfg_reg.low_hold_ms    <= cfg.data;
                REG_COOLDOWN_MS:    cfg_reg.refire_gap_ms  <= cfg.data;
                REG_PULSE_MODE:     cfg_reg.pulse_mode     <= cfg.data[0];
                REG_CHANNEL_COUNT:  cfg_reg.channel_count  <= cfg.data[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

endmodule

// ----- src/gts_chan_update.sv -----
module gts_chan_update
    import gts_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  cfg_t        cfg,
    input  sample_t     smp,
    input  chan_state_t st,
    output chan_state_t st_next,
    output result_t     res,
    output logic        wr_en
);

    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

    logic              in_use;
    logic              qualifies;
    logic [15:0]       need_ms;
    logic [TIME_W-1:0] hold_elapsed;
    logic [TIME_W-1:0] fire_elapsed;
    logic              hold_done;
    logic              cool_ok;
    logic              latch_mid;

    assign in_use = ({1'b0, smp.channel} < cfg.channel_count) &&
                    ({1'b0, smp.channel} < DEPTH_CNT);

    // Armed channels look for a low score, idle ones for a high score.
    assign qualifies    = st.armed ? (smp.score <= cfg.low_threshold)
                                   : (smp.score >= cfg.high_threshold);
    assign need_ms      = st.armed ? cfg.low_hold_ms : cfg.high_hold_ms;
    assign hold_elapsed = smp.now_ms - st.hold_start_ms;
    assign fire_elapsed = smp.now_ms - st.last_fire_ms;
    assign hold_done    = st.hold_running && (hold_elapsed >= {16'd0, need_ms});
    assign cool_ok      = (cfg.refire_gap_ms == 16'd0) || !st.ever_fired ||
                          (fire_elapsed >= {16'd0, cfg.refire_gap_ms});

    always_comb
    begin
        st_next   = st;
        latch_mid = st.output_latch;
        res.out_channel = smp.channel;
        res.out_score   = smp.score;
        res.fired       = 1'b0;
        res.active      = 1'b0;
        res.phase       = 2'd0;

        if (!qualifies)
        begin
            st_next.hold_running = 1'b0;
        end
        else if (!st.hold_running)
        begin
            st_next.hold_running  = 1'b1;
            st_next.hold_start_ms = smp.now_ms;
        end
        else if (hold_done)
        begin
            st_next.hold_running = 1'b0;
            st_next.armed        = !st.armed;
            if (st.armed && cool_ok)
            begin
                st_next.last_fire_ms = smp.now_ms;
                st_next.ever_fired   = 1'b1;
                res.fired            = 1'b1;
                latch_mid            = cfg.pulse_mode | !st.output_latch;
            end
        end

        // In pulse mode a set latch is shown once and then dropped.
        st_next.output_latch = latch_mid & !cfg.pulse_mode;

        if (smp.command == CMD_CLEAR || !in_use)
        begin
            res.fired = 1'b0;
        end
        else
        begin
            res.active = latch_mid;
            res.phase  = {st_next.armed, st_next.hold_running};
        end
    end

    assign wr_en = (smp.command == CMD_SAMPLE) && in_use;

endmodule

// ----- src/gesture_trigger_stabilizer_core.sv -----
// Gesture trigger stabiliser: per-channel hysteresis trigger with hold times
// and a fire cooldown.
//
// Channels: sample (sink) takes one request per score sample or clear command,
// result (source) returns exactly one result per request, in order. cfg is a
// register write port that is always ready; write it only while the block is idle.
//
// A request accepted at a clock edge is captured in the input register; its
// result is loaded into the result register once that register is empty or
// its result is being taken, and result.valid rises with that load.
// Throughput: one request per cycle while the result is not stalled, through the
// read-modify-write of the per-channel state registers between the two stages.
//
// Reset clears the configuration to its defaults, empties both stages and sets
// every channel idle and never fired. No clearing pass is needed.
// When the receiver stalls, the result holds steady; one more request is taken
// into the input register, after which sample.ready stays low until the
// result is taken.
module gesture_trigger_stabilizer_core
    import gts_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    gts_cfg_if.sink        cfg,
    gts_sample_if.sink     sample,
    gts_result_if.source   result
);

    localparam int DEPTH = (CHANNELS < MAX_CHANNELS) ? CHANNELS : MAX_CHANNELS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t        cfg_q;
    sample_t     smp_reg;
    logic        smp_valid_reg;
    result_t     res_reg;
    logic        res_valid_reg;
    logic        advance;

    logic [DEPTH-1:0]  armed_reg;
    logic [DEPTH-1:0]  hold_running_reg;
    logic [DEPTH-1:0]  ever_fired_reg;
    logic [DEPTH-1:0]  latch_reg;
    logic [TIME_W-1:0] hold_start_reg [DEPTH];
    logic [TIME_W-1:0] last_fire_reg  [DEPTH];

    logic [IDX_W-1:0]  idx;
    chan_state_t       st_cur;
    chan_state_t       st_next;
    result_t           res_next;
    logic              wr_en;

    gts_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    assign advance      = smp_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !smp_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            smp_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            smp_reg.command <= sample.command;
            smp_reg.channel <= sample.channel;
            smp_reg.score   <= sample.score;
            smp_reg.now_ms  <= sample.now_ms;
        end
    end

    // Channel indices are only used once in range, which the update logic checks.
    assign idx = IDX_W'(smp_reg.channel);

    always_comb
    begin
        st_cur.armed         = armed_reg[idx];
        st_cur.hold_running  = hold_running_reg[idx];
        st_cur.hold_start_ms = hold_start_reg[idx];
        st_cur.last_fire_ms  = last_fire_reg[idx];
        st_cur.ever_fired    = ever_fired_reg[idx];
        st_cur.output_latch  = latch_reg[idx];
    end

    gts_chan_update #(
        .DEPTH (DEPTH)
    ) u_chan_update (
        .cfg     (cfg_q),
        .smp     (smp_reg),
        .st      (st_cur),
        .st_next (st_next),
        .res     (res_next),
        .wr_en   (wr_en)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= '0;
            hold_running_reg <= '0;
            ever_fired_reg   <= '0;
            latch_reg        <= '0;
        end
        else if (advance)
        begin
            if (smp_reg.command == CMD_CLEAR)
            begin
                // Fire history is kept across a clear.
                armed_reg        <= '0;
                hold_running_reg <= '0;
                latch_reg        <= '0;
            end
            else if (wr_en)
            begin
                armed_reg[idx]        <= st_next.armed;
                hold_running_reg[idx] <= st_next.hold_running;
                ever_fired_reg[idx]   <= st_next.ever_fired;
                latch_reg[idx]        <= st_next.output_latch;
            end
        end
    end

    // Time stamps are only read while their hold or fire flag is set.
    always_ff @(posedge clk)
    begin
        if (advance && wr_en)
        begin
            hold_start_reg[idx] <= st_next.hold_start_ms;
            last_fire_reg[idx]  <= st_next.last_fire_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.out_channel = res_reg.out_channel;
    assign result.out_score   = res_reg.out_score;
    assign result.fired       = res_reg.fired;
    assign result.active      = res_reg.active;
    assign result.phase       = res_reg.phase;

endmodule

// ----- src/gts_checker.sv -----
module gts_checker
    import gts_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic [CHAN_W-1:0]  out_channel,
    input logic [SCORE_W-1:0] out_score,
    input logic               fired,
    input logic               active,
    input logic [1:0]         phase
);

    logic [1:0] pending_reg;
    logic       take_in;
    logic       take_out;

    assign take_in  = sample_valid && sample_ready;
    assign take_out = result_valid && result_ready;

    // Requests accepted whose results have not yet been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else if (take_in && !take_out)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (take_out && !take_in)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two requests outstanding");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 2'd0)
        else $error("result shown with no request outstanding");

    a_fire_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && fired) |-> phase == 2'd0)
        else $error("channel fired but did not return to idle");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(out_channel) && $stable(out_score) &&
             $stable(fired) && $stable(active) && $stable(phase)))
        else $error("stalled result changed");

endmodule

bind gesture_trigger_stabilizer_core gts_checker u_gts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .out_channel  (result.out_channel),
    .out_score    (result.out_score),
    .fired        (result.fired),
    .active       (result.active),
    .phase        (result.phase)
);
